### hdl/rsv_pkg.sv
// shared types, codes and constants for the requirement string validator
package rsv_pkg;

   // payload of one input transfer
   typedef struct packed {
      logic [7:0] spec_byte;
      logic       last_byte;
   } req_type;

   // payload of one result transfer
   typedef struct packed {
      logic       safe;
      logic [1:0] reject_cause;
   } rsp_type;

   // character classes of one byte
   typedef struct packed {
      logic alnum_us;
      logic name_char;
      logic extra_char;
      logic op_char;
      logic ver_char;
      logic open_bracket;
      logic close_bracket;
   } char_class_type;

   // recognizer states
   localparam logic [2:0] ST_START     = 3'd0;
   localparam logic [2:0] ST_NAME      = 3'd1;
   localparam logic [2:0] ST_EXT_FIRST = 3'd2;
   localparam logic [2:0] ST_EXT       = 3'd3;
   localparam logic [2:0] ST_AFTER_EXT = 3'd4;
   localparam logic [2:0] ST_OP        = 3'd5;
   localparam logic [2:0] ST_VER       = 3'd6;
   localparam logic [2:0] ST_FAIL      = 3'd7;

   // reject causes
   localparam logic [1:0] CAUSE_NONE     = 2'd0;
   localparam logic [1:0] CAUSE_TOO_LONG = 2'd1;
   localparam logic [1:0] CAUSE_MISMATCH = 2'd2;

   // length limit after reset
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd200;
   localparam logic [7:0] COUNT_MAX        = 8'hFF;

endpackage

### hdl/rsv_classify.sv
// character class decoder for one byte of the requirement string
module rsv_classify (
   input  logic [7:0]                 char_byte,
   output rsv_pkg::char_class_type    char_class
);

   logic is_upper;
   logic is_lower;
   logic is_digit;
   logic is_alnum_us;
   logic is_name;
   logic is_op;

   // basic ranges
   assign is_upper    = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
   assign is_lower    = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
   assign is_digit    = (char_byte >= 8'h30) && (char_byte <= 8'h39);
   assign is_alnum_us = is_upper || is_lower || is_digit || (char_byte == 8'h5F);

   // name chars add '.' and '-'
   assign is_name = is_alnum_us || (char_byte == 8'h2E) || (char_byte == 8'h2D);

   // operator chars < > = ! ~
   assign is_op = (char_byte == 8'h3C) || (char_byte == 8'h3E) || (char_byte == 8'h3D)
               || (char_byte == 8'h21) || (char_byte == 8'h7E);

   // class vector
   always_comb begin
      char_class.alnum_us      = is_alnum_us;
      char_class.name_char     = is_name;
      char_class.extra_char    = is_alnum_us || (char_byte == 8'h2C) || (char_byte == 8'h2D);
      char_class.op_char       = is_op;
      char_class.ver_char      = is_name || is_op || (char_byte == 8'h2B)
                              || (char_byte == 8'h2C) || (char_byte == 8'h2A);
      char_class.open_bracket  = (char_byte == 8'h5B);
      char_class.close_bracket = (char_byte == 8'h5D);
   end

endmodule

### hdl/rsv_match.sv
// recognizer state, byte count and verdict for the string in progress
module rsv_match (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     last_byte,
   input  rsv_pkg::char_class_type  char_class,
   input  logic [7:0]               max_length,
   output rsv_pkg::rsp_type         verdict
);

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [2:0] state_next;
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic [7:0] count_next;
   logic       too_long;
   logic       accepted;

   // pattern recognizer transition
   always_comb begin
      case (state_ff)
         rsv_pkg::ST_START: begin
            state_next = char_class.alnum_us ? rsv_pkg::ST_NAME : rsv_pkg::ST_FAIL;
         end
         rsv_pkg::ST_NAME: begin
            if (char_class.name_char) begin
               state_next = rsv_pkg::ST_NAME;
            end else if (char_class.open_bracket) begin
               state_next = rsv_pkg::ST_EXT_FIRST;
            end else if (char_class.op_char) begin
               state_next = rsv_pkg::ST_OP;
            end else begin
               state_next = rsv_pkg::ST_FAIL;
            end
         end
         rsv_pkg::ST_EXT_FIRST: begin
            state_next = char_class.extra_char ? rsv_pkg::ST_EXT : rsv_pkg::ST_FAIL;
         end
         rsv_pkg::ST_EXT: begin
            if (char_class.extra_char) begin
               state_next = rsv_pkg::ST_EXT;
            end else if (char_class.close_bracket) begin
               state_next = rsv_pkg::ST_AFTER_EXT;
            end else begin
               state_next = rsv_pkg::ST_FAIL;
            end
         end
         rsv_pkg::ST_AFTER_EXT: begin
            state_next = char_class.op_char ? rsv_pkg::ST_OP : rsv_pkg::ST_FAIL;
         end
         rsv_pkg::ST_OP, rsv_pkg::ST_VER: begin
            // the optional '=' after an operator is itself a version char
            state_next = char_class.ver_char ? rsv_pkg::ST_VER : rsv_pkg::ST_FAIL;
         end
         default: begin
            state_next = rsv_pkg::ST_FAIL;
         end
      endcase
   end

   // saturating byte count including this byte
   assign count_next = (count_ff == rsv_pkg::COUNT_MAX) ? count_ff : count_ff + 8'd1;

   // verdict for a string ending on this byte
   assign too_long = count_next > max_length;
   assign accepted = (state_next == rsv_pkg::ST_NAME) || (state_next == rsv_pkg::ST_AFTER_EXT)
                  || (state_next == rsv_pkg::ST_VER);

   always_comb begin
      if (too_long) begin
         verdict.reject_cause = rsv_pkg::CAUSE_TOO_LONG;
      end else if (accepted) begin
         verdict.reject_cause = rsv_pkg::CAUSE_NONE;
      end else begin
         verdict.reject_cause = rsv_pkg::CAUSE_MISMATCH;
      end
      verdict.safe = !too_long && accepted;
   end

   // next state: restart after the last byte
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      if (step) begin
         if (last_byte) begin
            state_in = rsv_pkg::ST_START;
            count_in = 8'd0;
         end else begin
            state_in = state_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsv_pkg::ST_START;
         count_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // a finished string leaves the recognizer at its start
   assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> (state_ff == rsv_pkg::ST_START) && (count_ff == 8'd0))
      else $error("recognizer not restarted after last byte");

   // the count only moves on a step
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(count_ff) && $stable(state_ff))
      else $error("recognizer moved without a step");

endmodule

### hdl/requirement_spec_validator_unit.sv
// top level of the requirement string validator: input register, recognizer, result register
// a last byte passes the input register, the single recognizer step, then the result register
// throughput: one byte per cycle, set by that step, unless a last byte waits on a held result
// the input register takes a new byte while a result waits, as long as it carries no last byte
// reset is synchronous and active high; it clears both valid bits and the recognizer,
// and sets the length limit to 200
module requirement_spec_validator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rsv_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsv_pkg::rsp_type  rsp_payload,
   input  logic              csr_write_en,
   input  logic [7:0]        csr_write_data
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   rsv_pkg::req_type        in_data_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   rsv_pkg::rsp_type        out_data_ff;
   logic [7:0]              max_length_ff;
   logic                    step;
   logic                    step_last;
   rsv_pkg::char_class_type char_class;
   rsv_pkg::rsp_type        verdict;

   // a byte moves on unless it ends a string and the result slot is full and not being taken
   assign step      = in_valid_ff && (!in_data_ff.last_byte || !out_valid_ff || rsp_ready);
   assign step_last = step && in_data_ff.last_byte;
   assign req_ready = !in_valid_ff || step;

   // length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= rsv_pkg::MAX_LENGTH_RESET;
      end else if (csr_write_en) begin
         max_length_ff <= csr_write_data;
      end
   end

   // input register
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   // byte classes and recognizer
   rsv_classify u_classify (
      .char_byte  (in_data_ff.spec_byte),
      .char_class (char_class)
   );

   rsv_match u_match (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .last_byte  (in_data_ff.last_byte),
      .char_class (char_class),
      .max_length (max_length_ff),
      .verdict    (verdict)
   );

   // result register
   assign out_valid_in = step_last || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_last) begin
         out_data_ff <= verdict;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // a string end always loads a result
   assert property (@(posedge clock) disable iff (reset)
      step_last |=> rsp_valid)
      else $error("string end produced no result");

   // the safe flag and the cause agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.safe == (rsp_payload.reject_cause == rsv_pkg::CAUSE_NONE)))
      else $error("safe flag disagrees with cause");

   // no result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a waiting result is never overwritten by a new string end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !step_last)
      else $error("result overwritten while stalled");

endmodule
